FILE: hw/rtl/rx_page_ring_tracker_macros.svh
// ---------------------------------------------------------------------------
// rx_page_ring_tracker_macros: assertion macros for the page ring tracker
// Concurrent assertion wrappers clocked on clk, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef RX_PAGE_RING_TRACKER_MACROS_SVH
`define RX_PAGE_RING_TRACKER_MACROS_SVH

// Same-cycle implication.
`define RPRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rx_page_ring_tracker: assertion failed");

// Next-cycle implication.
`define RPRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rx_page_ring_tracker: assertion failed");

`endif

FILE: hw/rtl/rprt_pkg.sv
// ---------------------------------------------------------------------------
// rprt_pkg: shared types and constants of the receive page ring tracker
// Verdict codes, register indexes, ring limits and item structs.
// ---------------------------------------------------------------------------
package rprt_pkg;

  localparam int PAGE_INDEX_BITS_DEF = 8;
  localparam int RESET_PAGE          = 12;
  localparam int LAST_PAGE_RESET     = 255;
  localparam int HEADER_BYTES        = 4;
  localparam int PAGE_BYTES          = 256;
  localparam int PAGE_SHIFT          = 8;
  localparam int MIN_PAYLOAD         = 60;
  localparam int MAX_PAYLOAD         = 1514;
  localparam int CFG_INDEX_BITS      = 1;

  typedef enum logic [1:0] {
    VERDICT_GOOD    = 2'd0,
    VERDICT_OVERRUN = 2'd1,
    VERDICT_SYNC    = 2'd2,
    VERDICT_SIZE    = 2'd3
  } verdict_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FIRST_PAGE = 1'b0,
    CFG_LAST_PAGE  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] first_page;
    logic [7:0] last_page;
  } ring_cfg_t;

  typedef struct packed {
    logic [7:0]  header_link;
    logic [15:0] byte_count;
    logic [7:0]  current_page;
  } header_t;

  typedef struct packed {
    verdict_t    verdict;
    logic [7:0]  next_page;
    logic [15:0] payload_length;
    logic        more_pending;
  } result_t;

endpackage

FILE: hw/rtl/rprt_ring_cfg.sv
// ---------------------------------------------------------------------------
// rprt_ring_cfg: ring limit registers
// Holds first and last page of the receive ring, written by index.
// ---------------------------------------------------------------------------
module rprt_ring_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rprt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                          cfg_data,
  output rprt_pkg::ring_cfg_t                 ring
);

  // Load the addressed limit on a write
  always_ff @(posedge clk) begin
    if (rst) begin
      ring.first_page <= 8'(rprt_pkg::RESET_PAGE);
      ring.last_page  <= 8'(rprt_pkg::LAST_PAGE_RESET);
    end else if (cfg_we) begin
      unique case (rprt_pkg::cfg_reg_t'(cfg_index))
        rprt_pkg::CFG_FIRST_PAGE: ring.first_page <= cfg_data;
        rprt_pkg::CFG_LAST_PAGE:  ring.last_page  <= cfg_data;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rprt_page_check.sv
// ---------------------------------------------------------------------------
// rprt_page_check: header check against the expected page
// Computes verdict and next page for one header, keeps the expected page.
// ---------------------------------------------------------------------------
module rprt_page_check #(
  parameter int PAGE_INDEX_BITS = rprt_pkg::PAGE_INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  rprt_pkg::ring_cfg_t ring,
  input  rprt_pkg::header_t   hdr,
  output rprt_pkg::result_t   res
);

  localparam int SUM_W = ((PAGE_INDEX_BITS > 9) ? PAGE_INDEX_BITS : 9) + 1;
  localparam int CMP_W = (PAGE_INDEX_BITS > 8) ? PAGE_INDEX_BITS : 8;
  localparam logic [16:0] ROUND_ADD =
    17'(rprt_pkg::HEADER_BYTES + rprt_pkg::PAGE_BYTES - 1);
  localparam logic [15:0] MIN_COUNT =
    16'(rprt_pkg::MIN_PAYLOAD + rprt_pkg::HEADER_BYTES);
  localparam logic [15:0] MAX_COUNT =
    16'(rprt_pkg::MAX_PAYLOAD + rprt_pkg::HEADER_BYTES);

  logic [PAGE_INDEX_BITS-1:0] expected_page;
  logic [PAGE_INDEX_BITS-1:0] expected_page_next;
  logic [16:0]                rounded;
  logic [8:0]                 pages;
  logic [8:0]                 ring_size;
  logic [SUM_W-1:0]           sum_raw;
  logic [SUM_W-1:0]           sum_wrap;
  logic                       in_range;
  logic                       size_ok;

  // Pages taken by the packet, rounded up, and the single wrap
  always_comb begin
    rounded   = {1'b0, hdr.byte_count} + ROUND_ADD;
    pages     = rounded[16:rprt_pkg::PAGE_SHIFT];
    ring_size = {1'b0, ring.last_page} - {1'b0, ring.first_page} + 9'd1;
    sum_raw   = SUM_W'(expected_page) + SUM_W'(pages);
    sum_wrap  = (sum_raw > SUM_W'(ring.last_page)) ? sum_raw - SUM_W'(ring_size)
                                                    : sum_raw;
    in_range  = (hdr.header_link >= ring.first_page) &&
                (hdr.header_link <= ring.last_page);
    size_ok   = (hdr.byte_count >= MIN_COUNT) && (hdr.byte_count <= MAX_COUNT);
  end

  // Pick the verdict and the new expected page
  always_comb begin
    res.more_pending = 1'b0;
    priority if (!in_range) begin
      res.verdict        = rprt_pkg::VERDICT_OVERRUN;
      expected_page_next = PAGE_INDEX_BITS'(ring.first_page);
    end else if (sum_wrap != SUM_W'(hdr.header_link)) begin
      res.verdict        = rprt_pkg::VERDICT_SYNC;
      expected_page_next = PAGE_INDEX_BITS'(hdr.header_link);
    end else begin
      res.verdict        = size_ok ? rprt_pkg::VERDICT_GOOD : rprt_pkg::VERDICT_SIZE;
      expected_page_next = sum_wrap[PAGE_INDEX_BITS-1:0];
      res.more_pending   = CMP_W'(expected_page_next) != CMP_W'(hdr.current_page);
    end
    res.next_page      = 8'(expected_page_next);
    res.payload_length = (hdr.byte_count >= 16'(rprt_pkg::HEADER_BYTES)) ?
                         hdr.byte_count - 16'(rprt_pkg::HEADER_BYTES) : 16'd0;
  end

  // Commit the expected page when the item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_page <= PAGE_INDEX_BITS'(rprt_pkg::RESET_PAGE);
    end else if (advance) begin
      expected_page <= expected_page_next;
    end
  end

endmodule

FILE: hw/rtl/rx_page_ring_tracker.sv
// ---------------------------------------------------------------------------
// rx_page_ring_tracker: receive page ring follower
//
//   channel  direction  handshake            payload
//   hdr      in         hdr_valid/hdr_stall  header_link, byte_count, current_page
//   res      out        res_valid/res_stall  verdict, next_page, payload_length,
//                                            more_pending
//   cfg      in         cfg_we               cfg_index, cfg_data
//
// One item per cycle while res is not stalled. An accepted header goes through
// the header register, then the result register; the check sits between them
// and updates the expected page as the item moves into the result register.
// Reset (rst, synchronous) empties both registers and loads the ring limits
// and expected page with their defaults. A stall on res holds the result and
// back-pressures hdr only once the header register is also occupied.
// ---------------------------------------------------------------------------
module rx_page_ring_tracker #(
  parameter int PAGE_INDEX_BITS = rprt_pkg::PAGE_INDEX_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                hdr_valid,
  output logic                                hdr_stall,
  input  logic [7:0]                          header_link,
  input  logic [15:0]                         byte_count,
  input  logic [7:0]                          current_page,
  output logic                                res_valid,
  input  logic                                res_stall,
  output logic [1:0]                          verdict,
  output logic [7:0]                          next_page,
  output logic [15:0]                         payload_length,
  output logic                                more_pending,
  input  logic                                cfg_we,
  input  logic [rprt_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [7:0]                          cfg_data
);

  rprt_pkg::ring_cfg_t ring;
  rprt_pkg::header_t   hdr_reg;
  rprt_pkg::result_t   check_res;
  rprt_pkg::result_t   res_reg;
  logic                hdr_full;
  logic                res_free;
  logic                advance;
  logic                hdr_accept;

  rprt_ring_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ring      (ring)
  );

  rprt_page_check #(
    .PAGE_INDEX_BITS (PAGE_INDEX_BITS)
  ) u_check (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ring    (ring),
    .hdr     (hdr_reg),
    .res     (check_res)
  );

  // Flow control between the two registers
  assign res_free   = !res_valid || !res_stall;
  assign advance    = hdr_full && res_free;
  assign hdr_stall  = hdr_full && !res_free;
  assign hdr_accept = hdr_valid && !hdr_stall;

  // Header register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_full <= 1'b0;
    end else if (hdr_accept) begin
      hdr_full <= 1'b1;
    end else if (advance) begin
      hdr_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_accept) begin
      hdr_reg.header_link  <= header_link;
      hdr_reg.byte_count   <= byte_count;
      hdr_reg.current_page <= current_page;
    end
  end

  // Result register: load on advance, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= check_res;
    end
  end

  assign verdict        = res_reg.verdict;
  assign next_page      = res_reg.next_page;
  assign payload_length = res_reg.payload_length;
  assign more_pending   = res_reg.more_pending;

endmodule

FILE: hw/rtl/rprt_checker.sv
// ---------------------------------------------------------------------------
// rprt_checker: port-level checks of the page ring tracker
// Watches the result channel and the verdict rules; bound to the top level.
// ---------------------------------------------------------------------------
`include "rx_page_ring_tracker_macros.svh"

module rprt_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_stall,
  input logic [1:0]  verdict,
  input logic [7:0]  next_page,
  input logic [15:0] payload_length,
  input logic        more_pending
);

  logic overrun;
  logic sync_lost;
  logic good;

  // Decode the shown verdict
  assign overrun   = res_valid && (verdict == rprt_pkg::VERDICT_OVERRUN);
  assign sync_lost = res_valid && (verdict == rprt_pkg::VERDICT_SYNC);
  assign good      = res_valid && (verdict == rprt_pkg::VERDICT_GOOD);

  `RPRT_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid && $stable(verdict) && $stable(next_page) && $stable(payload_length) && $stable(more_pending))
  `RPRT_ASSERT_NOW(a_overrun_idle, overrun, !more_pending)
  `RPRT_ASSERT_NOW(a_sync_idle, sync_lost, !more_pending)
  `RPRT_ASSERT_NOW(a_good_size, good, (payload_length >= 16'(rprt_pkg::MIN_PAYLOAD)) && (payload_length <= 16'(rprt_pkg::MAX_PAYLOAD)))

endmodule

bind rx_page_ring_tracker rprt_checker u_rprt_checker (
  .clk            (clk),
  .rst            (rst),
  .res_valid      (res_valid),
  .res_stall      (res_stall),
  .verdict        (verdict),
  .next_page      (next_page),
  .payload_length (payload_length),
  .more_pending   (more_pending)
);
